@@ sv/lsws_pkg.sv @@
`timescale 1ns / 1ps

package lsws_pkg;

    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data_out;
        logic [POS_W-1:0]         position;
        logic                     hit;
        logic                     empty_error;
        logic                     full_error;
        logic [COUNT_W-1:0]       count;
    } out_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

endpackage

@@ sv/lsws_front.sv @@
`timescale 1ns / 1ps

module lsws_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsws_pkg::in_t    s_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output lsws_pkg::cmd_t   cmd_data
);

    logic           valid_reg;
    logic           valid_next;
    lsws_pkg::cmd_t cmd_reg;
    lsws_pkg::cmd_t cmd_next;
    lsws_pkg::op_t  op_dec;

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        case (s_data.mode)
            lsws_pkg::MODE_PUSH:  op_dec = lsws_pkg::OP_PUSH;
            lsws_pkg::MODE_POP:   op_dec = lsws_pkg::OP_POP;
            lsws_pkg::MODE_FIND:  op_dec = lsws_pkg::OP_FIND;
            lsws_pkg::MODE_CLEAR: op_dec = lsws_pkg::OP_CLEAR;
            default:              op_dec = lsws_pkg::OP_CLEAR;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (s_valid && s_ready) begin
            valid_next     = 1'b1;
            cmd_next.op    = op_dec;
            cmd_next.value = s_data.value;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

@@ sv/lsws_queue.sv @@
`timescale 1ns / 1ps

module lsws_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lsws_pkg::cmd_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lsws_pkg::cmd_t   out_data
);

    lsws_pkg::cmd_t                  buf_reg [lsws_pkg::QDEPTH];
    logic [lsws_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [lsws_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [lsws_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [lsws_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [lsws_pkg::QCNT_W-1:0]     cnt_reg;
    logic [lsws_pkg::QCNT_W-1:0]     cnt_next;
    logic                            do_wr;
    logic                            do_rd;

    assign in_ready  = cnt_reg != lsws_pkg::QCNT_W'(lsws_pkg::QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_wr) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ sv/lsws_back.sv @@
`timescale 1ns / 1ps

module lsws_back #(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  lsws_pkg::cmd_t   cmd_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lsws_pkg::out_t   m_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_FIND = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CNT_W-1:0]                occ_reg;
    logic [CNT_W-1:0]                occ_next;
    logic [CNT_W-1:0]                occ_dec;
    logic [ADDR_W-1:0]               ptr_reg;
    logic [ADDR_W-1:0]               ptr_next;
    logic [ADDR_W-1:0]               k_reg;
    logic [ADDR_W-1:0]               k_next;
    logic signed [lsws_pkg::WORD_W-1:0] key_reg;
    logic signed [lsws_pkg::WORD_W-1:0] key_next;
    logic signed [lsws_pkg::WORD_W-1:0] entries_reg [DEPTH];
    logic signed [lsws_pkg::WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]               rd_addr;
    logic                            wr_en;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    lsws_pkg::out_t                  out_reg;
    lsws_pkg::out_t                  out_next;
    lsws_pkg::out_t                  res;
    logic                            res_load;
    logic [31:0]                     occ_ext;
    logic [31:0]                     k_ext;

    assign cmd_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign occ_dec   = occ_reg - CNT_W'(1);
    assign occ_ext   = 32'(occ_next);
    assign k_ext     = 32'(k_reg);

    always_comb begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        res_load       = 1'b0;
        res            = '0;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    case (cmd_data.op)
                        lsws_pkg::OP_PUSH: begin
                            res_load = 1'b1;
                            if (occ_reg == CNT_W'(DEPTH)) begin
                                res.full_error = 1'b1;
                            end else begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        lsws_pkg::OP_POP: begin
                            if (occ_reg == '0) begin
                                res_load        = 1'b1;
                                res.empty_error = 1'b1;
                            end else begin
                                rd_addr    = occ_dec[ADDR_W-1:0];
                                occ_next   = occ_dec;
                                state_next = ST_POP;
                            end
                        end
                        lsws_pkg::OP_FIND: begin
                            if (occ_reg == '0) begin
                                res_load = 1'b1;
                            end else begin
                                rd_addr    = occ_dec[ADDR_W-1:0];
                                ptr_next   = occ_dec[ADDR_W-1:0];
                                k_next     = '0;
                                key_next   = cmd_data.value;
                                state_next = ST_FIND;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                            occ_next = '0;
                        end
                    endcase
                end
            end
            ST_POP: begin
                res_load     = 1'b1;
                res.data_out = rd_data_reg;
                state_next   = ST_IDLE;
            end
            ST_FIND: begin
                if (rd_data_reg == key_reg) begin
                    res_load     = 1'b1;
                    res.hit      = 1'b1;
                    res.position = k_ext[lsws_pkg::POS_W-1:0];
                    state_next   = ST_IDLE;
                end else if (ptr_reg == '0) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_addr  = ptr_reg - ADDR_W'(1);
                    ptr_next = ptr_reg - ADDR_W'(1);
                    k_next   = k_reg + ADDR_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.count = occ_ext[lsws_pkg::COUNT_W-1:0];
        if (res_load) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_reg[occ_reg[ADDR_W-1:0]] <= cmd_data.value;
        end
        rd_data_reg <= entries_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
        ptr_reg <= ptr_next;
        k_reg   <= k_next;
        key_reg <= key_next;
        out_reg <= out_next;
    end

endmodule

@@ sv/lifo_stack_with_search.sv @@
// Bounded LIFO of signed 32-bit words with a top-to-bottom linear search.
// Input channel s_valid/s_ready/s_data carries one transaction per operation:
// push, pop, find or clear. Output channel m_valid/m_ready/m_data returns
// exactly one result transaction per input, in order, with the count after
// the operation.
// Path: an input register decodes the mode, a two-entry command queue feeds
// the execution unit, which owns the word memory and a result register.
// Push and clear finish in the execution unit's idle state; a pop adds one
// memory read, and a find reads and compares one stored word per cycle
// through the single memory read port, from the top of the stack down,
// stopping at the first match (position k) or after the bottom entry.
// Throughput: one push or clear per cycle while m_ready stays high; the
// execution unit runs one operation at a time.
// Reset clears the occupancy, the queue and all valid flags; memory contents
// are not cleared and need no clearing pass. When m_ready is low the result
// is held, the execution unit stops, and the queue and input register fill
// before s_ready drops.
`timescale 1ns / 1ps

module lifo_stack_with_search #(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsws_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lsws_pkg::out_t   m_data
);

    logic           fr_valid;
    logic           fr_ready;
    lsws_pkg::cmd_t fr_data;
    logic           q_valid;
    logic           q_ready;
    lsws_pkg::cmd_t q_data;

    lsws_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    lsws_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    lsws_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ test/tb_lifo_stack_with_search.sv @@
`timescale 1ns / 1ps

module tb_lifo_stack_with_search;

    localparam int STACK_DEPTH = 64;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_CYCLES = STACK_DEPTH + 40;
    localparam int CYCLE_LIMIT = 1000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lsws_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lsws_pkg::out_t m_data;

    lsws_pkg::in_t pending_items[$];
    lsws_pkg::out_t expected_results[$];
    logic signed [lsws_pkg::WORD_W-1:0] queued_words[$];

    logic signed [lsws_pkg::WORD_W-1:0] stack_words[STACK_DEPTH];
    int stack_fill = 0;

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int ready_pattern = 0;
    int pattern_left = 0;
    int stall_left = 0;
    int queued_total = 0;

    lifo_stack_with_search #(.DEPTH(STACK_DEPTH)) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic lsws_pkg::out_t predict_stack_op(input lsws_pkg::in_t txn);
        lsws_pkg::out_t r;
        r = '0;
        case (lsws_pkg::op_t'(txn.mode))
            lsws_pkg::OP_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    r.full_error = 1'b1;
                end else begin
                    stack_words[stack_fill] = txn.value;
                    stack_fill++;
                end
            end
            lsws_pkg::OP_POP: begin
                if (stack_fill == 0) begin
                    r.empty_error = 1'b1;
                end else begin
                    stack_fill--;
                    r.data_out = stack_words[stack_fill];
                end
            end
            lsws_pkg::OP_FIND: begin
                for (int k = 0; k < stack_fill; k++) begin
                    if (!r.hit && stack_words[stack_fill - 1 - k] == txn.value) begin
                        r.hit = 1'b1;
                        r.position = lsws_pkg::POS_W'(k);
                    end
                end
            end
            default: begin
                stack_fill = 0;
            end
        endcase
        r.count = lsws_pkg::COUNT_W'(stack_fill);
        return r;
    endfunction

    task automatic queue_op(input lsws_pkg::op_t op,
                            input logic signed [lsws_pkg::WORD_W-1:0] word);
        lsws_pkg::in_t txn;
        txn.mode = op;
        txn.value = word;
        pending_items.push_back(txn);
        queued_total++;
        case (op)
            lsws_pkg::OP_PUSH:
                if (queued_words.size() < STACK_DEPTH) queued_words.push_back(word);
            lsws_pkg::OP_POP:
                if (queued_words.size() > 0) void'(queued_words.pop_back());
            lsws_pkg::OP_CLEAR: queued_words.delete();
            default: ;
        endcase
    endtask

    function automatic logic signed [lsws_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return $signed($urandom_range(0, 7)) - 4;
            7: return 32'sh7fff_ffff;
            8: return 32'sh8000_0000;
            default: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_stack_op(s_data));
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = $urandom_range(100, 300);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = $urandom_range(0, 15);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results in order and stall on a changing pattern
    always @(posedge aclk) begin
        lsws_pkg::out_t want;
        logic rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.data_out !== want.data_out) begin
                        $display("%0t: data_out expected %0d actual %0d",
                                 $time, want.data_out, m_data.data_out);
                        error_count++;
                    end
                    if (m_data.position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, m_data.position);
                        error_count++;
                    end
                    if (m_data.hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, want.hit, m_data.hit);
                        error_count++;
                    end
                    if (m_data.empty_error !== want.empty_error) begin
                        $display("%0t: empty_error expected %0b actual %0b",
                                 $time, want.empty_error, m_data.empty_error);
                        error_count++;
                    end
                    if (m_data.full_error !== want.full_error) begin
                        $display("%0t: full_error expected %0b actual %0b",
                                 $time, want.full_error, m_data.full_error);
                        error_count++;
                    end
                    if (m_data.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, m_data.count);
                        error_count++;
                    end
                end
            end
            if (pattern_left == 0) begin
                ready_pattern = $urandom_range(0, 2);
                pattern_left = $urandom_range(20, 300);
            end
            pattern_left--;
            case (ready_pattern)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 20);
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                    end
                end
            endcase
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        int kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_op(lsws_pkg::OP_POP, 32'sd9);
        queue_op(lsws_pkg::OP_FIND, 32'sd0);
        queue_op(lsws_pkg::OP_PUSH, 32'sh7fff_ffff);
        queue_op(lsws_pkg::OP_PUSH, 32'sh8000_0000);
        queue_op(lsws_pkg::OP_PUSH, 32'sd0);
        queue_op(lsws_pkg::OP_PUSH, -32'sd1);
        queue_op(lsws_pkg::OP_PUSH, 32'sd5);
        queue_op(lsws_pkg::OP_PUSH, 32'sd5);
        queue_op(lsws_pkg::OP_FIND, 32'sd5);
        queue_op(lsws_pkg::OP_FIND, 32'sh8000_0000);
        queue_op(lsws_pkg::OP_FIND, 32'sh7fff_ffff);
        queue_op(lsws_pkg::OP_FIND, 32'sd123);
        queue_op(lsws_pkg::OP_POP, 32'sd0);
        queue_op(lsws_pkg::OP_POP, 32'sd0);
        queue_op(lsws_pkg::OP_FIND, 32'sd5);
        queue_op(lsws_pkg::OP_CLEAR, 32'sh5555_aaaa);
        queue_op(lsws_pkg::OP_POP, 32'sd0);
        queue_op(lsws_pkg::OP_FIND, -32'sd1);
        queue_op(lsws_pkg::OP_PUSH, -32'sd1);
        queue_op(lsws_pkg::OP_FIND, -32'sd1);
        queue_op(lsws_pkg::OP_POP, 32'sd0);
        queue_op(lsws_pkg::OP_POP, 32'sd0);
        wait_for_drain();

        queued_total = 0;
        while (queued_total < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                n = $urandom_range(1, 16);
                if ($urandom_range(0, 5) == 0)
                    n = STACK_DEPTH + 3 - queued_words.size();
                repeat (n) queue_op(lsws_pkg::OP_PUSH, pick_word());
            end else if (kind < 50) begin
                repeat ($urandom_range(1, 4)) begin
                    if (queued_words.size() > 0)
                        queue_op(lsws_pkg::OP_FIND,
                                 queued_words[$urandom_range(0, queued_words.size() - 1)]);
                    else
                        queue_op(lsws_pkg::OP_FIND, pick_word());
                end
            end else if (kind < 60) begin
                queue_op(lsws_pkg::OP_FIND, pick_word());
            end else if (kind < 78) begin
                n = $urandom_range(1, 8);
                if ($urandom_range(0, 7) == 0)
                    n = queued_words.size() + 2;
                repeat (n) queue_op(lsws_pkg::OP_POP, pick_word());
            end else if (kind < 84) begin
                queue_op(lsws_pkg::OP_CLEAR, $urandom);
            end else begin
                repeat ($urandom_range(1, 5))
                    queue_op(lsws_pkg::op_t'($urandom_range(0, 3)), $urandom);
            end
            if ($urandom_range(0, 99) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
